// ===== hw/rtl/four_cycle_counter_top_assert.svh =====
// assertion macros for four_cycle_counter_top
`ifndef FOUR_CYCLE_COUNTER_TOP_ASSERT_SVH
`define FOUR_CYCLE_COUNTER_TOP_ASSERT_SVH

// combinational implication, checked out of reset
`define FCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define FCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/fcc_pkg.sv =====
package fcc_pkg;

  localparam int MAX_VERTICES_DEF = 64;

  localparam int VERTEX_W = 6;
  localparam int VCOUNT_W = 7;
  localparam int COUNT_W  = 21;
  localparam int EDGE_W   = 11;
  // accumulator holds the doubled count plus one guard bit
  localparam int ACC_W    = COUNT_W + 2;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
  localparam logic [EDGE_W-1:0]   EDGE_MAX     = '1;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
    logic                edge_valid;
    logic                last_edge;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] cycle_count;
    logic               has_cycle;
    logic [EDGE_W-1:0]  edge_total;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_A,
    ST_WR_B,
    ST_CNT,
    ST_DRAIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch item, read row of vertex_a
    logic wr_a;        // write row a with bit b, read row b
    logic wr_b;        // write row b with bit a, count the edge
    logic pair_init;   // start pair walk at (0,1)
    logic pair_issue;  // read current pair and advance
    logic finish;      // latch result, clear graph
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic edge_ok;
    logic in_last;
    logic item_last;
    logic dup;
    logic pair_last;
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/fcc_datapath.sv =====
module fcc_datapath #(
  parameter int MAX_VERTICES = fcc_pkg::MAX_VERTICES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fcc_pkg::in_item_t              in_data,
  input  logic                           cfg_we,
  input  logic [fcc_pkg::VCOUNT_W-1:0]   cfg_wdata,
  input  fcc_pkg::cmd_t                  cmd,
  output fcc_pkg::sts_t                  sts,
  output logic                           out_valid,
  input  logic                           out_stall,
  output fcc_pkg::out_item_t             out_data
);
  import fcc_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int NB = (MAX_VERTICES + 7) / 8;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int TW = 2 * CW;
  localparam logic [MAX_VERTICES-1:0] ROW_ONE = {{(MAX_VERTICES-1){1'b0}}, 1'b1};
  localparam logic [IW-1:0] LAST_U = IW'(MAX_VERTICES - 2);
  localparam logic [IW-1:0] LAST_V = IW'(MAX_VERTICES - 1);

  function automatic logic [3:0] pop8(input logic [7:0] x);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(x[i]);
    end
    return n;
  endfunction

  // configuration
  logic [VCOUNT_W-1:0] vertex_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VCOUNT_RESET;
    end else if (cfg_we) begin
      vertex_count_r <= cfg_wdata;
    end
  end

  // latched item
  logic [VERTEX_W-1:0] a_r, b_r;
  logic                last_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      a_r    <= in_data.vertex_a;
      b_r    <= in_data.vertex_b;
      last_r <= in_data.last_edge;
    end
  end

  // adjacency memory, row valid bits stand in for clearing
  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid_r;
  logic [MAX_VERTICES-1:0] rdata0_r, rdata1_r;
  logic                    rv0_r, rv1_r;
  logic [IW-1:0]           raddr0, raddr1, waddr;
  logic [MAX_VERTICES-1:0] rd0, rd1, wdata;
  logic                    we;

  logic [IW-1:0] u_r, v_r;

  assign raddr0 = cmd.pair_issue ? u_r : (cmd.wr_a ? IW'(b_r) : IW'(in_data.vertex_a));
  assign raddr1 = v_r;
  assign rd0    = rv0_r ? rdata0_r : '0;
  assign rd1    = rv1_r ? rdata1_r : '0;
  assign we     = cmd.wr_a | cmd.wr_b;
  assign waddr  = cmd.wr_a ? IW'(a_r) : IW'(b_r);
  assign wdata  = rd0 | (cmd.wr_a ? (ROW_ONE << b_r) : (ROW_ONE << a_r));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0_r <= mem[raddr0];
    rdata1_r <= mem[raddr1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rv0_r       <= 1'b0;
      rv1_r       <= 1'b0;
    end else begin
      rv0_r <= row_valid_r[raddr0];
      rv1_r <= row_valid_r[raddr1];
      if (cmd.finish) begin
        row_valid_r <= '0;
      end else if (we) begin
        row_valid_r[waddr] <= 1'b1;
      end
    end
  end

  // edge counter
  logic [EDGE_W-1:0] edge_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      edge_cnt_r <= '0;
    end else if (cmd.wr_b && edge_cnt_r != EDGE_MAX) begin
      edge_cnt_r <= edge_cnt_r + EDGE_W'(1);
    end
  end

  // pair walk
  always_ff @(posedge clk) begin
    if (cmd.pair_init) begin
      u_r <= '0;
      v_r <= IW'(1);
    end else if (cmd.pair_issue) begin
      if (v_r == LAST_V) begin
        u_r <= u_r + IW'(1);
        v_r <= u_r + IW'(2);
      end else begin
        v_r <= v_r + IW'(1);
      end
    end
  end

  // count pipeline: read, byte counts, common count, pair term, accumulate
  logic                    s1_r, s2_r, s3_r, s4_r;
  logic [NB*8-1:0]         common;
  logic [3:0]              bc_r [NB];
  logic [CW-1:0]           c_sum, c_r;
  logic [TW-1:0]           prod, term_r;
  logic [ACC_W-1:0]        acc_r;
  logic [ACC_W:0]          acc_sum;

  assign common = (NB*8)'(rd0 & rd1);

  always_comb begin
    c_sum = '0;
    for (int i = 0; i < NB; i++) begin
      c_sum = c_sum + CW'(bc_r[i]);
    end
  end

  // c*(c-1) is even, and zero for c of zero
  assign prod    = TW'(c_r) * (TW'(c_r) - TW'(1));
  assign acc_sum = {1'b0, acc_r} + (ACC_W+1)'(term_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= 1'b0;
      s2_r <= 1'b0;
      s3_r <= 1'b0;
      s4_r <= 1'b0;
    end else begin
      s1_r <= cmd.pair_issue;
      s2_r <= s1_r;
      s3_r <= s2_r;
      s4_r <= s3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NB; i++) begin
      bc_r[i] <= pop8(common[i*8 +: 8]);
    end
    c_r    <= c_sum;
    term_r <= prod >> 1;
  end

  // saturating accumulate
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      acc_r <= '0;
    end else if (s4_r) begin
      acc_r <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
    end
  end

  // result: halve, then saturate
  logic [COUNT_W-1:0] res_count;
  assign res_count = (acc_r[ACC_W-1:COUNT_W+1] != '0) ? COUNT_MAX : acc_r[COUNT_W:1];

  logic      out_valid_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r.cycle_count <= res_count;
      out_data_r.has_cycle   <= (res_count != '0);
      out_data_r.edge_total  <= edge_cnt_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status
  logic a_in_range, b_in_range;
  assign a_in_range = (7'(in_data.vertex_a) < vertex_count_r) &&
                      (32'(in_data.vertex_a) < MAX_VERTICES);
  assign b_in_range = (7'(in_data.vertex_b) < vertex_count_r) &&
                      (32'(in_data.vertex_b) < MAX_VERTICES);

  assign sts.edge_ok   = in_data.edge_valid && (in_data.vertex_a != in_data.vertex_b) &&
                         a_in_range && b_in_range;
  assign sts.in_last   = in_data.last_edge;
  assign sts.item_last = last_r;
  assign sts.dup       = ((rd0 & (ROW_ONE << b_r)) != '0);
  assign sts.pair_last = (u_r == LAST_U) && (v_r == LAST_V);
  assign sts.pipe_busy = s1_r | s2_r | s3_r | s4_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

// ===== hw/rtl/fcc_controller.sv =====
module fcc_controller (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  fcc_pkg::sts_t sts,
  output fcc_pkg::cmd_t cmd,
  output logic          in_stall
);
  import fcc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (sts.edge_ok) begin
            state_nxt = ST_CHK_A;
          end else if (sts.in_last) begin
            cmd.pair_init = 1'b1;
            state_nxt     = ST_CNT;
          end
        end
      end
      ST_CHK_A: begin
        if (sts.dup) begin
          if (sts.item_last) begin
            cmd.pair_init = 1'b1;
            state_nxt     = ST_CNT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.wr_a  = 1'b1;
          state_nxt = ST_WR_B;
        end
      end
      ST_WR_B: begin
        cmd.wr_b = 1'b1;
        if (sts.item_last) begin
          cmd.pair_init = 1'b1;
          state_nxt     = ST_CNT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CNT: begin
        cmd.pair_issue = 1'b1;
        if (sts.pair_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy && sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/four_cycle_counter_top.sv =====
// a last item's result appears after any row check or row writes for an edge on it, a pair
// walk of one pair a cycle over every vertex pair of MAX_VERTICES, and the pipeline drain;
// it waits longer while an earlier result is still stalled
// intake: a non-final item storing nothing keeps input open; a duplicate edge holds it for a
// row check, a new edge for both rows' read-modify-write, a final item until the result loads
// reset: rst_n synchronous active low; vertex_count to 64, row valid bits empty the graph
module four_cycle_counter_top #(
  parameter int MAX_VERTICES = fcc_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // edge items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fcc_pkg::in_item_t             in_data,
  // count results
  output logic                          out_valid,
  input  logic                          out_stall,
  output fcc_pkg::out_item_t            out_data,
  // vertex count register
  input  logic                          cfg_we,
  input  logic [fcc_pkg::VCOUNT_W-1:0]  cfg_wdata
);
  import fcc_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: item intake, edge read-modify-write, pair walk, result hand-off
  fcc_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // datapath: adjacency memory, edge counter, popcount pipeline, accumulator,
  // output register (next graph may load while a result waits)
  fcc_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/fcc_checker.sv =====
`include "four_cycle_counter_top_assert.svh"

module fcc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input fcc_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input fcc_pkg::out_item_t out_data
);
  import fcc_pkg::*;

  // a waiting result holds
  `FCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_data), "result changed while stalled")

  // flag agrees with the count
  `FCC_ASSERT_NOW(a_has_cycle, out_valid,
                  out_data.has_cycle == (out_data.cycle_count != '0), "has_cycle mismatch")

  // an empty non-final item leaves the input open for the next item
  `FCC_ASSERT_NEXT(a_bare_item,
                   in_valid && !in_stall && !in_data.edge_valid && !in_data.last_edge,
                   !in_stall, "stall after empty item")

  // a final item starts the count
  `FCC_ASSERT_NEXT(a_last_busy, in_valid && !in_stall && in_data.last_edge,
                   in_stall, "no count after last item")

endmodule

bind four_cycle_counter_top fcc_checker u_fcc_checker (.*);
